>>> hdl/srpq_pkg.sv
// ----------------------------------------------------------------------------
// srpq_pkg
// Shared types and constants of the sorted ring priority queue.
// ----------------------------------------------------------------------------
package srpq_pkg;

  // field widths fixed by the channel format
  localparam int TIME_IN_W = 16;
  localparam int INFO_W    = 8;
  localparam int CNT_W     = 5;
  localparam int CAP_W     = 5;
  localparam int STATUS_W  = 2;

  // default build
  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DEQ,
    S_DONE
  } state_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ENQ_FIRST,
    OP_ENQ_START,
    OP_WALK_SHIFT,
    OP_WALK_PLACE,
    OP_DEQ_START,
    OP_DEQ_TAKE,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_go;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/srpq_if.sv
// ----------------------------------------------------------------------------
// srpq_if
// Valid/ready channels of the sorted ring priority queue.
// ----------------------------------------------------------------------------
interface srpq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [srpq_pkg::TIME_IN_W-1:0] entry_time;
  logic [srpq_pkg::INFO_W-1:0]    entry_info;

  modport source (output valid, kind, entry_time, entry_info, input ready);
  modport sink   (input valid, kind, entry_time, entry_info, output ready);
endinterface

interface srpq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           out_valid;
  logic [srpq_pkg::TIME_IN_W-1:0] out_time;
  logic [srpq_pkg::INFO_W-1:0]    out_info;
  logic [srpq_pkg::STATUS_W-1:0]  status;
  logic [srpq_pkg::CNT_W-1:0]     count;

  modport source (output valid, out_valid, out_time, out_info, status, count, input ready);
  modport sink   (input valid, out_valid, out_time, out_info, status, count, output ready);
endinterface

>>> hdl/srpq_ram.sv
// ----------------------------------------------------------------------------
// srpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/srpq_ctrl.sv
// ----------------------------------------------------------------------------
// srpq_ctrl
// Sequencer: decodes a transaction, steps the insertion walk, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module srpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  input  srpq_pkg::dp_sts_t  sts_i,
  output srpq_pkg::ctl_cmd_t cmd_o,
  output logic               in_ready_o
);

  srpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == srpq_pkg::KIND_DEQ) begin
            state_d = sts_i.empty ? srpq_pkg::S_DONE : srpq_pkg::S_DEQ;
          end else begin
            state_d = (sts_i.full || sts_i.empty) ? srpq_pkg::S_DONE : srpq_pkg::S_WALK;
          end
        end
      end
      srpq_pkg::S_WALK: begin
        if (!sts_i.walk_go) begin
          state_d = srpq_pkg::S_DONE;
        end
      end
      srpq_pkg::S_DEQ: begin
        state_d = srpq_pkg::S_DONE;
      end
      srpq_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          state_d = srpq_pkg::S_IDLE;
        end
      end
      default: state_d = srpq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op       = srpq_pkg::OP_NONE;
    cmd_o.load_out = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      srpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == srpq_pkg::KIND_DEQ) begin
            cmd_o.op = sts_i.empty ? srpq_pkg::OP_REFUSE_EMPTY : srpq_pkg::OP_DEQ_START;
          end else if (sts_i.full) begin
            cmd_o.op = srpq_pkg::OP_REFUSE_FULL;
          end else if (sts_i.empty) begin
            cmd_o.op = srpq_pkg::OP_ENQ_FIRST;
          end else begin
            cmd_o.op = srpq_pkg::OP_ENQ_START;
          end
        end
      end
      srpq_pkg::S_WALK: begin
        cmd_o.op = sts_i.walk_go ? srpq_pkg::OP_WALK_SHIFT : srpq_pkg::OP_WALK_PLACE;
      end
      srpq_pkg::S_DEQ: begin
        cmd_o.op = srpq_pkg::OP_DEQ_TAKE;
      end
      srpq_pkg::S_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o.op = srpq_pkg::OP_NONE;
      end
    endcase
  end

endmodule

>>> hdl/srpq_dp.sv
// ----------------------------------------------------------------------------
// srpq_dp
// Datapath: ring pointers, slot RAM, insertion walk registers, result and
// output registers, capacity register.
// ----------------------------------------------------------------------------
module srpq_dp #(
  parameter int DEPTH     = srpq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = srpq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srpq_pkg::CAP_W-1:0]     cfg_data_i,
  input  srpq_pkg::ctl_cmd_t             cmd_i,
  output srpq_pkg::dp_sts_t              sts_o,
  input  logic [srpq_pkg::TIME_IN_W-1:0] in_time_i,
  input  logic [srpq_pkg::INFO_W-1:0]    in_info_i,
  input  logic                           out_ready_i,
  output logic                           out_vld_o,
  output logic                           out_valid_o,
  output logic [srpq_pkg::TIME_IN_W-1:0] out_time_o,
  output logic [srpq_pkg::INFO_W-1:0]    out_info_o,
  output logic [srpq_pkg::STATUS_W-1:0]  out_status_o,
  output logic [srpq_pkg::CNT_W-1:0]     out_count_o
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = srpq_pkg::CNT_W;
  localparam int INFO_W  = srpq_pkg::INFO_W;
  localparam int ENTRY_W = TIME_BITS + INFO_W;
  localparam int AW      = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] sz);
    logic [AW-1:0] inc;
    inc = AW'(i) + AW'(1);
    if (inc >= AW'(sz)) begin
      ring_next = '0;
    end else begin
      ring_next = inc[IDX_W-1:0];
    end
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] sz);
    logic [AW-1:0] dec;
    dec = AW'(sz) - AW'(1);
    if (i == '0) begin
      ring_prev = dec[IDX_W-1:0];
    end else begin
      ring_prev = i - IDX_W'(1);
    end
  endfunction

  logic [srpq_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]           size;
  logic [IDX_W-1:0]           head_q, tail_q, nxt_tail;
  logic [CNT_W-1:0]           cnt_q;
  logic [IDX_W-1:0]           pos_q, prv_q;
  logic [TIME_BITS-1:0]       nt_q;
  logic [INFO_W-1:0]          ni_q;

  logic                          res_valid_q;
  logic [TIME_BITS-1:0]          res_time_q;
  logic [INFO_W-1:0]             res_info_q;
  srpq_pkg::status_e             res_status_q;

  logic                          out_vld_q;
  logic                          out_valid_q;
  logic [srpq_pkg::TIME_IN_W-1:0] out_time_q;
  logic [INFO_W-1:0]             out_info_q;
  logic [srpq_pkg::STATUS_W-1:0] out_status_q;
  logic [CNT_W-1:0]              out_count_q;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [INFO_W-1:0]    rd_info;
  logic                 out_free;

  // capacity 0 acts as 1, anything above the built depth as the depth
  always_comb begin
    if (cap_q == '0) begin
      size = CNT_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      size = CNT_W'(DEPTH);
    end else begin
      size = cap_q;
    end
  end

  assign nxt_tail = ring_next(tail_q, size);
  assign rd_time  = ram_rdata[ENTRY_W-1:INFO_W];
  assign rd_info  = ram_rdata[INFO_W-1:0];
  assign out_free = !out_vld_q || out_ready_i;

  assign sts_o.full     = (cnt_q >= size);
  assign sts_o.empty    = (cnt_q == '0);
  // ram_rdata holds the slot before pos_q
  assign sts_o.walk_go  = (pos_q != head_q) && (nt_q < rd_time);
  assign sts_o.out_free = out_free;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {TIME_BITS'(in_time_i), in_info_i};
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (cmd_i.op)
      srpq_pkg::OP_ENQ_FIRST: begin
        ram_we = 1'b1;
      end
      srpq_pkg::OP_ENQ_START: begin
        ram_re    = 1'b1;
        ram_raddr = ring_prev(nxt_tail, size);
      end
      srpq_pkg::OP_WALK_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = ring_prev(prv_q, size);
      end
      srpq_pkg::OP_WALK_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {nt_q, ni_q};
      end
      srpq_pkg::OP_DEQ_START: begin
        ram_re    = 1'b1;
        ram_raddr = head_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  srpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ring control; a capacity write empties the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= srpq_pkg::CAP_RESET;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_data_i;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        srpq_pkg::OP_ENQ_FIRST: begin
          head_q <= '0;
          tail_q <= '0;
          cnt_q  <= CNT_W'(1);
        end
        srpq_pkg::OP_ENQ_START: begin
          tail_q <= nxt_tail;
        end
        srpq_pkg::OP_WALK_PLACE: begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        srpq_pkg::OP_DEQ_TAKE: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            head_q <= '0;
            tail_q <= '0;
          end else begin
            head_q <= ring_next(head_q, size);
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // walk and result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      srpq_pkg::OP_ENQ_START: begin
        nt_q  <= TIME_BITS'(in_time_i);
        ni_q  <= in_info_i;
        pos_q <= nxt_tail;
        prv_q <= ring_prev(nxt_tail, size);
      end
      srpq_pkg::OP_WALK_SHIFT: begin
        pos_q <= prv_q;
        prv_q <= ring_prev(prv_q, size);
      end
      srpq_pkg::OP_ENQ_FIRST, srpq_pkg::OP_WALK_PLACE: begin
        res_valid_q  <= 1'b0;
        res_time_q   <= '0;
        res_info_q   <= '0;
        res_status_q <= srpq_pkg::ST_DONE;
      end
      srpq_pkg::OP_REFUSE_FULL: begin
        res_valid_q  <= 1'b0;
        res_time_q   <= '0;
        res_info_q   <= '0;
        res_status_q <= srpq_pkg::ST_FULL;
      end
      srpq_pkg::OP_REFUSE_EMPTY: begin
        res_valid_q  <= 1'b0;
        res_time_q   <= '0;
        res_info_q   <= '0;
        res_status_q <= srpq_pkg::ST_EMPTY;
      end
      srpq_pkg::OP_DEQ_TAKE: begin
        res_valid_q  <= 1'b1;
        res_time_q   <= rd_time;
        res_info_q   <= rd_info;
        res_status_q <= srpq_pkg::ST_DONE;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_valid_q  <= res_valid_q;
      out_time_q   <= srpq_pkg::TIME_IN_W'(res_time_q);
      out_info_q   <= res_info_q;
      out_status_q <= res_status_q;
      out_count_q  <= cnt_q;
    end
  end

  assign out_vld_o    = out_vld_q;
  assign out_valid_o  = out_valid_q;
  assign out_time_o   = out_time_q;
  assign out_info_o   = out_info_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

  a_empty_ptrs_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with non-zero ring pointers");

  a_place_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == srpq_pkg::OP_WALK_PLACE && !cfg_we_i) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insertion did not bump the entry count");

  a_entry_only_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_valid_q) |-> (out_status_q == srpq_pkg::ST_DONE))
    else $error("dequeued entry presented with a refusal status");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_count_q)))
    else $error("pending result overwritten");

endmodule

>>> hdl/sorted_ring_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue
// Priority queue of (time, info) entries kept in ascending time order in a
// ring of slots; an enqueue sinks the new entry back past later times.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// in_i      in   valid/ready         kind, entry_time, entry_info
// out_o     out  valid/ready         out_valid, out_time, out_info, status, count
// cfg       in   cfg_we_i (no wait)  cfg_data_i = capacity
//
// Dequeue: accept with a slot RAM read, take the entry into the result register,
// then load the output register. Refused operations and an enqueue into an empty
// queue go from accept straight to the output load. Otherwise the walk moves each
// later entry back one slot, with one read and one write of the slot RAM per cycle.
// One transaction at a time; the output register lets the next one start
// while a result waits. Reset empties the queue; no clearing pass.
// A capacity write empties the queue.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue #(
  parameter int DEPTH     = srpq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = srpq_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srpq_pkg::CAP_W-1:0] cfg_data_i,
  srpq_in_if.sink                    in_i,
  srpq_out_if.source                 out_o
);

  srpq_pkg::ctl_cmd_t cmd;
  srpq_pkg::dp_sts_t  sts;

  srpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  srpq_dp #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_time_i    (in_i.entry_time),
    .in_info_i    (in_i.entry_info),
    .out_ready_i  (out_o.ready),
    .out_vld_o    (out_o.valid),
    .out_valid_o  (out_o.out_valid),
    .out_time_o   (out_o.out_time),
    .out_info_o   (out_o.out_info),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.count)
  );

endmodule
